### src/point_segment_distance_unit_defines.svh
// Assertion macros shared by the point-to-segment distance RTL.
`ifndef POINT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, masked during reset.
`define PSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psd: same-cycle check failed");

// Next-cycle implication, checked on clk, masked during reset.
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psd: next-cycle check failed");

`endif

### src/psd_pkg.sv
// Shared constants for the point-to-segment distance unit.
package psd_pkg;

  localparam int DIST_W   = 25;
  localparam int REGION_W = 2;

  localparam logic [REGION_W-1:0] REG_START = 2'd0;
  localparam logic [REGION_W-1:0] REG_END   = 2'd1;
  localparam logic [REGION_W-1:0] REG_PERP  = 2'd2;

endpackage

### src/point_segment_distance_unit.sv
// Top level of the point-to-segment distance unit.
//
// Usage:
//   Input channel: in_valid / in_stall with point, segment start and segment
//   end as signed COORD_BITS coordinates. One transaction per query.
//   Output channel: out_valid / out_stall with distance (unsigned, scaled by
//   2^DIST_FRAC_BITS, truncated) and region (start, end or perpendicular).
//   Throughput: one transaction per cycle while no result is held stalled on the output.
//   Pipeline: difference, product, region, partial-product and scaling stages,
//   then the restoring divider (one quotient bit per stage, QW = 2*COORD_BITS+1+
//   2*DIST_FRAC_BITS quotient bits) and the square root (one root bit per stage, SW = (QW+1)/2 root bits).
//   Stall: the whole pipeline holds while a result sits on the output and
//   out_stall is high; in_stall follows in the same cycle. Bubbles are
//   carried, nothing is dropped or repeated.
//   Reset: rst (synchronous) clears all valid bits; the pipeline starts empty.
module point_segment_distance_unit #(
  parameter int COORD_BITS     = 16,
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psd_pkg::DIST_W-1:0]    distance,
  output logic [psd_pkg::REGION_W-1:0]  region
);

  `include "point_segment_distance_unit_defines.svh"

  localparam int DW  = COORD_BITS + 1;        // coordinate differences
  localparam int PW  = 2 * DW;                // products
  localparam int DTW = PW + 1;                // dot / cross sums
  localparam int SQW = 2 * COORD_BITS + 1;    // squared lengths, |cross|
  localparam int LW  = (SQW + 1) / 2;         // low half of |cross|
  localparam int HW  = SQW - LW;
  localparam int C2W = 2 * SQW;               // cross squared
  localparam int NW  = C2W + 2 * DIST_FRAC_BITS;
  localparam int QW  = SQW + 2 * DIST_FRAC_BITS;
  localparam int SW  = (QW + 1) / 2;
  localparam int RGW = psd_pkg::REGION_W;

  // One global advance: the pipeline moves unless a held result is stalled.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: difference vectors v1 = end-start, v2 = p-start, v3 = p-end.
  logic                 s1_valid;
  logic signed [DW-1:0] v1x, v1y, v2x, v2y, v3x, v3y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      v1x <= {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
      v1y <= {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
      v2x <= {point_x[COORD_BITS-1], point_x} - {start_x[COORD_BITS-1], start_x};
      v2y <= {point_y[COORD_BITS-1], point_y} - {start_y[COORD_BITS-1], start_y};
      v3x <= {point_x[COORD_BITS-1], point_x} - {end_x[COORD_BITS-1], end_x};
      v3y <= {point_y[COORD_BITS-1], point_y} - {end_y[COORD_BITS-1], end_y};
    end
  end

  // Stage 2: all the small products.
  logic                 s2_valid;
  logic signed [PW-1:0] pd1x, pd1y, pd2x, pd2y, pcx, pcy;
  logic signed [PW-1:0] q1x, q1y, q2x, q2y, q3x, q3y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      pd1x <= v1x * v2x;
      pd1y <= v1y * v2y;
      pd2x <= v1x * v3x;
      pd2y <= v1y * v3y;
      pcx  <= v1x * v2y;
      pcy  <= v1y * v2x;
      q1x  <= v1x * v1x;
      q1y  <= v1y * v1y;
      q2x  <= v2x * v2x;
      q2y  <= v2y * v2y;
      q3x  <= v3x * v3x;
      q3y  <= v3y * v3y;
    end
  end

  // Stage 3: dot products pick the region; cross magnitude and lengths.
  logic signed [DTW-1:0] dot1, dot2, cross_sum;
  logic [SQW-1:0]        len1, len2sq, len3;
  logic [RGW-1:0]        region_next;
  logic [SQW-1:0]        sq_next;
  logic [DTW-1:0]        cross_abs;

  always_comb begin
    dot1      = DTW'(pd1x) + DTW'(pd1y);
    dot2      = DTW'(pd2x) + DTW'(pd2y);
    cross_sum = DTW'(pcx) - DTW'(pcy);
    cross_abs = cross_sum[DTW-1] ? -cross_sum : cross_sum;
    len1      = q1x[SQW-1:0] + q1y[SQW-1:0];
    len2sq    = q2x[SQW-1:0] + q2y[SQW-1:0];
    len3      = q3x[SQW-1:0] + q3y[SQW-1:0];
    if (dot1 <= 0) begin
      region_next = psd_pkg::REG_START;
      sq_next     = len2sq;
    end else if (dot2 >= 0) begin
      region_next = psd_pkg::REG_END;
      sq_next     = len3;
    end else begin
      region_next = psd_pkg::REG_PERP;
      sq_next     = len2sq;
    end
  end

  logic           s3_valid;
  logic [RGW-1:0] s3_region;
  logic [SQW-1:0] s3_sq, s3_cmag, s3_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
    if (adv) begin
      s3_region <= region_next;
      s3_sq     <= sq_next;
      s3_cmag   <= cross_abs[SQW-1:0];
      s3_len    <= len1;
    end
  end

  // Stage 4: |cross|^2 as three half-width partial products.
  logic              s4_valid;
  logic [RGW-1:0]    s4_region;
  logic [SQW-1:0]    s4_sq, s4_len;
  logic [2*HW-1:0]   pp_hh;
  logic [HW+LW-1:0]  pp_hl;
  logic [2*LW-1:0]   pp_ll;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
    if (adv) begin
      s4_region <= s3_region;
      s4_sq     <= s3_sq;
      s4_len    <= s3_len;
      pp_hh     <= s3_cmag[SQW-1:LW] * s3_cmag[SQW-1:LW];
      pp_hl     <= s3_cmag[SQW-1:LW] * s3_cmag[LW-1:0];
      pp_ll     <= s3_cmag[LW-1:0] * s3_cmag[LW-1:0];
    end
  end

  // Stage 5: sum partials, scale the dividend and the endpoint radicand.
  logic [C2W-1:0] c2;
  logic [NW-1:0]  dividend;

  always_comb begin
    c2       = (C2W'(pp_hh) << (2 * LW)) + (C2W'(pp_hl) << (LW + 1)) + C2W'(pp_ll);
    dividend = NW'(c2) << (2 * DIST_FRAC_BITS);
  end

  logic           s5_valid;
  logic [RGW-1:0] s5_region;
  logic [SQW-1:0] s5_num_hi, s5_len;
  logic [QW-1:0]  s5_num_lo, s5_byp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
    if (adv) begin
      s5_region <= s4_region;
      s5_len    <= s4_len;
      s5_num_hi <= dividend[NW-1:QW];
      s5_num_lo <= dividend[QW-1:0];
      s5_byp    <= QW'(s4_sq) << (2 * DIST_FRAC_BITS);
    end
  end

  // Divider: cross^2 * 2^(2F) / |v1|^2. Endpoint cases ride along as side data.
  logic               dv_valid;
  logic [QW-1:0]      dv_quot;
  logic [RGW+QW-1:0]  dv_side;

  psd_div #(
    .RW     (SQW),
    .QW     (QW),
    .SIDE_W (RGW + QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (s5_valid),
    .num_hi   (s5_num_hi),
    .num_lo   (s5_num_lo),
    .den      (s5_len),
    .side_in  ({s5_region, s5_byp}),
    .out_vld  (dv_valid),
    .quot     (dv_quot),
    .side_out (dv_side)
  );

  logic [RGW-1:0] dv_region;
  logic [QW-1:0]  rad;

  assign dv_region = dv_side[RGW+QW-1:QW];
  assign rad       = (dv_region == psd_pkg::REG_PERP) ? dv_quot : dv_side[QW-1:0];

  // Square root of the selected radicand.
  logic [SW-1:0]  root;
  logic [RGW-1:0] sq_region;

  psd_sqrt #(
    .RADW   (QW),
    .SIDE_W (RGW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (dv_valid),
    .rad      (rad),
    .side_in  (dv_region),
    .out_vld  (out_valid),
    .root     (root),
    .side_out (sq_region)
  );

  assign distance = psd_pkg::DIST_W'(root);
  assign region   = sq_region;

  `PSD_ASSERT_IMP(a_stall_back, out_valid && out_stall, in_stall)
  `PSD_ASSERT_IMP(a_empty_after_reset, $past(rst), !out_valid)
  `PSD_ASSERT_NEXT(a_hold_on_stall, in_stall, $stable(s1_valid) && $stable(v1x))
  `PSD_ASSERT_IMP(a_region_code, out_valid,
    region == psd_pkg::REG_START || region == psd_pkg::REG_END ||
    region == psd_pkg::REG_PERP)

endmodule

### src/psd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module psd_div #(
  parameter int RW     = 33,
  parameter int QW     = 49,
  parameter int SIDE_W = 51
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [RW-1:0]     num_hi,
  input  logic [QW-1:0]     num_lo,
  input  logic [RW-1:0]     den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [QW-1:0]     quot,
  output logic [SIDE_W-1:0] side_out
);

  // num_hi < den is required so the quotient fits in QW bits.
  logic              vld  [QW];
  logic [RW-1:0]     rem  [QW];
  logic [QW-1:0]     word [QW];
  logic [RW-1:0]     dreg [QW];
  logic [SIDE_W-1:0] side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic              src_vld;
    logic [RW-1:0]     src_rem;
    logic [QW-1:0]     src_word;
    logic [RW-1:0]     src_den;
    logic [SIDE_W-1:0] src_side;
    logic [RW:0]       trial;
    logic              ge;
    logic [RW:0]       diff;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = num_hi;
      assign src_word = num_lo;
      assign src_den  = den;
      assign src_side = side_in;
    end else begin : g_rest
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_word = word[k-1];
      assign src_den  = dreg[k-1];
      assign src_side = side[k-1];
    end

    assign trial = {src_rem, src_word[QW-1]};
    assign ge    = trial >= {1'b0, src_den};
    assign diff  = trial - {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_vld;
      end
      if (adv) begin
        rem[k]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
        word[k] <= {src_word[QW-2:0], ge};
        dreg[k] <= src_den;
        side[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld[QW-1];
  assign quot     = word[QW-1];
  assign side_out = side[QW-1];

endmodule

### src/psd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module psd_sqrt #(
  parameter int RADW   = 49,
  parameter int SIDE_W = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic [RADW-1:0]        rad,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_vld,
  output logic [(RADW+1)/2-1:0]  root,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int SW = (RADW + 1) / 2;
  localparam int RE = 2 * SW;

  logic              vld  [SW];
  logic [SW:0]       rem  [SW];
  logic [SW-1:0]     rt   [SW];
  logic [RE-1:0]     word [SW];
  logic [SIDE_W-1:0] side [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stg
    logic              src_vld;
    logic [SW:0]       src_rem;
    logic [SW-1:0]     src_rt;
    logic [RE-1:0]     src_word;
    logic [SIDE_W-1:0] src_side;
    logic [SW+2:0]     t;
    logic [SW+2:0]     trial;
    logic              ge;
    logic [SW+2:0]     diff;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = '0;
      assign src_rt   = '0;
      assign src_word = RE'(rad);
      assign src_side = side_in;
    end else begin : g_rest
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_rt   = rt[k-1];
      assign src_word = word[k-1];
      assign src_side = side[k-1];
    end

    assign t     = {src_rem, src_word[RE-1:RE-2]};
    assign trial = {1'b0, src_rt, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_vld;
      end
      if (adv) begin
        // remainder stays at most twice the partial root
        rem[k]  <= ge ? diff[SW:0] : t[SW:0];
        rt[k]   <= {src_rt[SW-2:0], ge};
        word[k] <= {src_word[RE-3:0], 2'b00};
        side[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld[SW-1];
  assign root     = rt[SW-1];
  assign side_out = side[SW-1];

endmodule

### verif/tb_top.sv
// Testbench for the point-to-segment distance unit: directed table plus random queries.
`timescale 1ns / 100ps

module tb_top;

  localparam int CW        = 16;
  localparam int FRAC      = 8;
  localparam int LATENCY   = 79;
  localparam int N_RANDOM  = 1100;
  localparam int CYCLE_CAP = 400000;

  // One query and its result.
  typedef struct packed {
    logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  } query_t;

  typedef struct packed {
    logic [psd_pkg::DIST_W-1:0]   dist_val;
    logic [psd_pkg::REGION_W-1:0] reg_code;
  } answer_t;

  // Directed row: a query, and optionally a hand-derived answer.
  typedef struct packed {
    query_t  q;
    logic    has_answer;
    answer_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] point_x = '0, point_y = '0;
  logic signed [CW-1:0] start_x = '0, start_y = '0;
  logic signed [CW-1:0] end_x = '0, end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [psd_pkg::DIST_W-1:0]   distance;
  logic [psd_pkg::REGION_W-1:0] region;

  always #5 clk = ~clk;

  point_segment_distance_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y),
    .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .region(region)
  );

  answer_t pending_answers[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  stimulus_done = 1'b0;
  bit  long_holdoff = 1'b0;   // requested by the sender, served by the receiver

  // floor(sqrt(n)) on 128-bit values, bit by bit.
  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // Scaled length of a difference vector.
  function automatic logic [63:0] scaled_norm(longint dx, longint dy);
    logic [127:0] s;
    s = 128'(dx * dx) + 128'(dy * dy);
    return isqrt(s << (2 * FRAC));
  endfunction

  // Expected distance and region for one query.
  function automatic answer_t predict_distance(query_t q);
    longint v1x, v1y, v2x, v2y, v3x, v3y, c, len2;
    logic [127:0] quot;
    logic [63:0]  d;
    answer_t a;
    v1x = longint'(q.ex) - longint'(q.sx);
    v1y = longint'(q.ey) - longint'(q.sy);
    v2x = longint'(q.px) - longint'(q.sx);
    v2y = longint'(q.py) - longint'(q.sy);
    v3x = longint'(q.px) - longint'(q.ex);
    v3y = longint'(q.py) - longint'(q.ey);
    if (v1x * v2x + v1y * v2y <= 0) begin
      d = scaled_norm(v2x, v2y);
      a.reg_code = psd_pkg::REG_START;
    end else if (v1x * v3x + v1y * v3y >= 0) begin
      d = scaled_norm(v3x, v3y);
      a.reg_code = psd_pkg::REG_END;
    end else begin
      // interior: cross^2 * 2^2F / |v1|^2, then root
      c = v1x * v2y - v1y * v2x;
      if (c < 0) c = -c;
      len2 = v1x * v1x + v1y * v1y;
      quot = ((128'(c) * 128'(c)) << (2 * FRAC)) / 128'(len2);
      d = isqrt(quot);
      a.reg_code = psd_pkg::REG_PERP;
    end
    a.dist_val = d[psd_pkg::DIST_W-1:0];
    return a;
  endfunction

  function automatic row_t mk(int px, int py, int sx, int sy, int ex, int ey,
                              bit known = 1'b0, int dist_val = 0,
                              logic [psd_pkg::REGION_W-1:0] rc = psd_pkg::REG_START);
    row_t r;
    r.q = '{px: CW'(px), py: CW'(py), sx: CW'(sx), sy: CW'(sy),
            ex: CW'(ex), ey: CW'(ey)};
    r.has_answer = known;
    r.a = '{dist_val: psd_pkg::DIST_W'(dist_val), reg_code: rc};
    return r;
  endfunction

  // Random coordinate: mostly full range, sometimes small or an extreme.
  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // Random query: sometimes degenerate, sometimes shaped toward interior cases.
  function automatic query_t rand_query();
    query_t q;
    int k;
    q.sx = CW'(rand_coord()); q.sy = CW'(rand_coord());
    q.ex = CW'(rand_coord()); q.ey = CW'(rand_coord());
    q.px = CW'(rand_coord()); q.py = CW'(rand_coord());
    k = $urandom_range(0, 9);
    if (k == 0) begin
      q.ex = q.sx; q.ey = q.sy;
    end else if (k < 4) begin
      // point near the segment midpoint, likely interior
      q.px = CW'((int'(q.sx) + int'(q.ex)) / 2 + int'($urandom_range(0, 200)) - 100);
      q.py = CW'((int'(q.sy) + int'(q.ey)) / 2 + int'($urandom_range(0, 200)) - 100);
    end
    return q;
  endfunction

  // Offer one transaction and hold it until accepted; valid drops only for a gap.
  task automatic send_query(query_t q, answer_t want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_answers.push_back(want);
    in_valid <= 1'b1;
    point_x <= q.px; point_y <= q.py;
    start_x <= q.sx; start_y <= q.sy;
    end_x   <= q.ex; end_y   <= q.ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender: directed table, then random stream.
  initial begin
    row_t rows[$];
    query_t rq;
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, psd_pkg::REG_START));
    rows.push_back(mk(3, 4, 0, 0, 0, 0, 1, 5 * 256, psd_pkg::REG_START));   // degenerate
    rows.push_back(mk(-3, 4, 0, 0, 10, 0, 1, 5 * 256, psd_pkg::REG_START));
    rows.push_back(mk(0, 7, 0, 0, 10, 0, 1, 7 * 256, psd_pkg::REG_START));  // dot1 exactly 0
    rows.push_back(mk(10, 7, 0, 0, 10, 0, 1, 7 * 256, psd_pkg::REG_END));   // dot2 exactly 0
    rows.push_back(mk(13, 4, 0, 0, 10, 0, 1, 5 * 256, psd_pkg::REG_END));
    rows.push_back(mk(5, 6, 0, 0, 10, 0, 1, 6 * 256, psd_pkg::REG_PERP));
    rows.push_back(mk(5, -6, 0, 0, 10, 0, 1, 6 * 256, psd_pkg::REG_PERP));
    rows.push_back(mk(1, 1, 0, 0, 2, 2, 1, 0, psd_pkg::REG_PERP));
    rows.push_back(mk(1, 0, 0, 0, 1, 1));
    rows.push_back(mk(32767, 32767, -32768, -32768, -32768, -32768));
    rows.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767));
    rows.push_back(mk(32767, -32768, -32768, 32767, -32768, 32767));
    rows.push_back(mk(0, 32767, -32768, -32768, 32767, -32768));
    rows.push_back(mk(0, -32768, -32768, 32767, 32767, 32767));
    rows.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767));
    rows.push_back(mk(32767, -32768, -32768, -32768, 32767, 32767));
    rows.push_back(mk(-1, -1, 1, -32768, -1, 32767));
    rows.push_back(mk(21845, -21846, -1, 0, 0, -1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].has_answer)
        send_query(rows[i].q, rows[i].a);
      else
        send_query(rows[i].q, predict_distance(rows[i].q));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) long_holdoff = 1'b1;
      rq = rand_query();
      send_query(rq, predict_distance(rq));
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: random stall, plus one long hold-off so the pipe backs up.
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_holdoff) begin
        long_holdoff = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;   // stretch with no stalls
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        wait_cycles = $urandom_range(0, 12);
        if (wait_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // Scoreboard: compare each accepted transaction with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result with no query outstanding: distance %0d region %0d",
               distance, region);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (distance !== want.dist_val) begin
          $error("distance: expected %0d, got %0d", want.dist_val, distance);
          fail_count++;
        end
        if (region !== want.reg_code) begin
          $error("region: expected %0d, got %0d", want.reg_code, region);
          fail_count++;
        end
      end
    end
  end

  // Run end and watchdog.
  initial begin
    fork
      begin
        wait (stimulus_done && pending_answers.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_CAP) begin
          @(posedge clk);
          cycle_count++;
        end
        fail_count++;
        $error("timeout after %0d cycles", cycle_count);
      end
    join_any
    if (fail_count == 0 && pending_answers.size() == 0)
      $display("[point_segment_distance_unit] OK");
    else
      $display("[point_segment_distance_unit] ERROR");
    $finish;
  end

endmodule
